// ----- rtl/core/bpc_pkg.sv -----
// Shared types, constants and helpers for the barometer pressure compensation block.
package bpc_pkg;

   localparam int RawW      = 16;
   localparam int CoeffW    = 16;
   localparam int AdcW      = 10;
   localparam int AdcShift  = RawW - AdcW;
   localparam int AccW      = 32;
   localparam int NumStages = 6;
   localparam int NumCoeffs = 6;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = CoeffW;

   localparam int ShA11   = 14;
   localparam int ShA1    = 11;
   localparam int ShB2    = 15;
   localparam int ShC22   = 1;
   localparam int ShA2    = 16;
   localparam int ShY1    = 10;
   localparam int ShOut   = 13;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_A0  = 3'd0,
      CSR_B1  = 3'd1,
      CSR_B2  = 3'd2,
      CSR_C12 = 3'd3,
      CSR_C11 = 3'd4,
      CSR_C22 = 3'd5
   } csr_index_type;

   typedef logic signed [AccW-1:0]   acc_type;
   typedef logic signed [CoeffW-1:0] coeff_type;
   typedef logic [AdcW-1:0]          adc_type;

   typedef struct packed {
      coeff_type a0;
      coeff_type b1;
      coeff_type b2;
      coeff_type c12;
      coeff_type c11;
      coeff_type c22;
   } coeff_set_type;

   typedef struct packed {
      logic [NumStages-1:0] en;
   } pipe_ctrl_type;

   function automatic acc_type sext_coeff(input coeff_type c);
      return acc_type'({{(AccW-CoeffW){c[CoeffW-1]}}, c});
   endfunction

   function automatic acc_type mul_adc(input acc_type a, input adc_type u);
      acc_type ue;
      ue = acc_type'({{(AccW-AdcW){1'b0}}, u});
      return a * ue;
   endfunction

endpackage

// ----- rtl/core/bpc_stream_if.sv -----
// Valid/ready channel interfaces for sample pairs and compensated results.
interface bpc_req_if;
   import bpc_pkg::*;
   logic            valid;
   logic            ready;
   logic [RawW-1:0] raw_pressure;
   logic [RawW-1:0] raw_temperature;
   modport source(output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_rsp_if;
   import bpc_pkg::*;
   logic      valid;
   logic      ready;
   coeff_type comp_pressure_count;
   modport source(output valid, output comp_pressure_count, input ready);
   modport sink(input valid, input comp_pressure_count, output ready);
endinterface

// ----- rtl/core/bpc_coeff_regs.sv -----
// Coefficient register file written through the CSR port.
module bpc_coeff_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bpc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [bpc_pkg::CsrDataW-1:0]  csr_wdata,
   output bpc_pkg::coeff_set_type        coeffs
);
   import bpc_pkg::*;

   coeff_set_type coeffs_ff;
   coeff_set_type coeffs_in;

   always_comb begin
      coeffs_in = coeffs_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_A0:  coeffs_in.a0  = coeff_type'(csr_wdata);
            CSR_B1:  coeffs_in.b1  = coeff_type'(csr_wdata);
            CSR_B2:  coeffs_in.b2  = coeff_type'(csr_wdata);
            CSR_C12: coeffs_in.c12 = coeff_type'(csr_wdata);
            CSR_C11: coeffs_in.c11 = coeff_type'(csr_wdata);
            CSR_C22: coeffs_in.c22 = coeff_type'(csr_wdata);
            default: coeffs_in = coeffs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
      end else begin
         coeffs_ff <= coeffs_in;
      end
   end

   assign coeffs = coeffs_ff;

endmodule

// ----- rtl/core/bpc_pipe_ctrl.sv -----
// Per-stage valid bits and stall chain for the compensation pipeline.
module bpc_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output bpc_pkg::pipe_ctrl_type ctrl
);
   import bpc_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;
   logic [NumStages-1:0] vpred;

   // a stage takes data when empty or when its content moves on
   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || out_ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      vpred = {valid_ff[NumStages-2:0], in_valid};
      for (int i = 0; i < NumStages; i++) begin
         valid_in[i] = ready[i] ? vpred[i] : valid_ff[i];
      end
      ctrl.en = ready & vpred;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NumStages-1];

endmodule

// ----- rtl/core/bpc_datapath.sv -----
// Six-stage fixed-point datapath of the compensation polynomial.
module bpc_datapath (
   input  logic                     clock,
   input  bpc_pkg::pipe_ctrl_type   ctrl,
   input  bpc_pkg::coeff_set_type   coeffs,
   input  logic [bpc_pkg::RawW-1:0] raw_pressure,
   input  logic [bpc_pkg::RawW-1:0] raw_temperature,
   output bpc_pkg::coeff_type       comp_pressure_count
);
   import bpc_pkg::*;

   // stage 1: counts and first products
   adc_type padc1_ff, tadc1_ff, padc1_in, tadc1_in;
   acc_type c11x1_ff, c12x2_1_ff, c22x2_ff;
   acc_type c11x1_in, c12x2_1_in, c22x2_in;
   // stage 2: a11, a2
   adc_type padc2_ff, tadc2_ff;
   acc_type a11_ff, c12x2_2_ff, a2_2_ff;
   acc_type a11_in, a2_2_in;
   // stage 3: a1
   adc_type padc3_ff, tadc3_ff;
   acc_type a1_ff, a2_3_ff, a1_in;
   // stage 4: second products
   acc_type a1x1_ff, a2x2_4_ff, a1x1_in, a2x2_4_in;
   // stage 5: y1
   acc_type y1_ff, a2x2_5_ff, y1_in;
   // stage 6: result
   coeff_type comp_ff, comp_in;
   acc_type   acc6;

   always_comb begin
      padc1_in   = adc_type'(raw_pressure >> AdcShift);
      tadc1_in   = adc_type'(raw_temperature >> AdcShift);
      c11x1_in   = mul_adc(sext_coeff(coeffs.c11), padc1_in);
      c12x2_1_in = mul_adc(sext_coeff(coeffs.c12), tadc1_in);
      c22x2_in   = mul_adc(sext_coeff(coeffs.c22), tadc1_in);

      a11_in  = ((sext_coeff(coeffs.b1) <<< ShA11) + c11x1_ff) >>> ShA11;
      a2_2_in = ((sext_coeff(coeffs.b2) <<< ShB2) + (c22x2_ff >>> ShC22)) >>> ShA2;

      a1_in = ((a11_ff <<< ShA1) + c12x2_2_ff) >>> ShA1;

      a1x1_in   = mul_adc(a1_ff, padc3_ff);
      a2x2_4_in = mul_adc(a2_3_ff, tadc3_ff);

      y1_in = ((sext_coeff(coeffs.a0) <<< ShY1) + a1x1_ff) >>> ShY1;

      acc6    = ((y1_ff <<< ShY1) + a2x2_5_ff) >>> ShOut;
      comp_in = acc6[CoeffW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         padc1_ff   <= padc1_in;
         tadc1_ff   <= tadc1_in;
         c11x1_ff   <= c11x1_in;
         c12x2_1_ff <= c12x2_1_in;
         c22x2_ff   <= c22x2_in;
      end
      if (ctrl.en[1]) begin
         padc2_ff   <= padc1_ff;
         tadc2_ff   <= tadc1_ff;
         a11_ff     <= a11_in;
         c12x2_2_ff <= c12x2_1_ff;
         a2_2_ff    <= a2_2_in;
      end
      if (ctrl.en[2]) begin
         padc3_ff <= padc2_ff;
         tadc3_ff <= tadc2_ff;
         a1_ff    <= a1_in;
         a2_3_ff  <= a2_2_ff;
      end
      if (ctrl.en[3]) begin
         a1x1_ff   <= a1x1_in;
         a2x2_4_ff <= a2x2_4_in;
      end
      if (ctrl.en[4]) begin
         y1_ff     <= y1_in;
         a2x2_5_ff <= a2x2_4_ff;
      end
      if (ctrl.en[5]) begin
         comp_ff <= comp_in;
      end
   end

   assign comp_pressure_count = comp_ff;

endmodule

// ----- rtl/core/barometer_pressure_compensation.sv -----
// Top level of the barometer pressure compensation pipeline.
//
//   channel  direction  handshake     payload
//   req      in         valid/ready   raw_pressure[15:0], raw_temperature[15:0]
//   rsp      out        valid/ready   comp_pressure_count[15:0] signed
//   csr      in         csr_we        csr_index[2:0], csr_wdata[15:0]
//
// One transaction per cycle while rsp is not stalled; the pipeline has six register stages
// (two multiplier ranks, four shift-add ranks) between req acceptance and rsp valid.
// Synchronous reset clears all stage valid bits and the coefficients.
// A stalled rsp holds its data; bubbles collapse, so req stays ready while any stage is empty.
module barometer_pressure_compensation (
   input  logic                         clock,
   input  logic                         reset,
   bpc_req_if.sink                      req,
   bpc_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [bpc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bpc_pkg::CsrDataW-1:0] csr_wdata
);
   import bpc_pkg::*;

   coeff_set_type coeffs;
   pipe_ctrl_type ctrl;

   bpc_coeff_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coeffs    (coeffs)
   );

   bpc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .ctrl      (ctrl)
   );

   bpc_datapath u_dp (
      .clock               (clock),
      .ctrl                (ctrl),
      .coeffs              (coeffs),
      .raw_pressure        (req.raw_pressure),
      .raw_temperature     (req.raw_temperature),
      .comp_pressure_count (rsp.comp_pressure_count)
   );

endmodule

// ----- rtl/core/bpc_checker.sv -----
// Port-level assertions for the compensation pipeline and their bind.
module bpc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bpc_pkg::CoeffW-1:0] rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // input stalls only with a full pipe behind a stalled output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without downstream stall");

   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req not ready while rsp ready");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("transaction did not arrive after six cycles");

endmodule

bind barometer_pressure_compensation bpc_checker u_bpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.comp_pressure_count)
);

// ----- test/barometer_pressure_compensation_test.sv -----
// Self-checking testbench for barometer_pressure_compensation: predicts each compensated count.
module barometer_pressure_compensation_test;
   import bpc_pkg::*;

   class compensation_checker;
      coeff_type coeffs[NumCoeffs];
      coeff_type expected_counts[$];
      int        samples;
      int        results;
      int        errors;

      function new();
         foreach (coeffs[i]) coeffs[i] = '0;
      endfunction

      function void write_coeff(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] value);
         if (index < NumCoeffs) coeffs[index] = value;
      endfunction

      function coeff_type compensate(logic [RawW-1:0] rp, logic [RawW-1:0] rt);
         int padc, tadc, a0, b1, b2, c12, c11, c22;
         int a11, a1, a2, y1, acc;
         padc = int'(rp[RawW-1:AdcShift]);
         tadc = int'(rt[RawW-1:AdcShift]);
         a0   = int'(coeffs[CSR_A0]);
         b1   = int'(coeffs[CSR_B1]);
         b2   = int'(coeffs[CSR_B2]);
         c12  = int'(coeffs[CSR_C12]);
         c11  = int'(coeffs[CSR_C11]);
         c22  = int'(coeffs[CSR_C22]);
         a11  = ((b1 <<< ShA11) + c11 * padc) >>> ShA11;
         a1   = ((a11 <<< ShA1) + c12 * tadc) >>> ShA1;
         a2   = ((b2 <<< ShB2) + ((c22 * tadc) >>> ShC22)) >>> ShA2;
         y1   = ((a0 <<< ShY1) + a1 * padc) >>> ShY1;
         acc  = ((y1 <<< ShY1) + a2 * tadc) >>> ShOut;
         return acc[CoeffW-1:0];
      endfunction

      function void note_sample(logic [RawW-1:0] rp, logic [RawW-1:0] rt);
         expected_counts.push_back(compensate(rp, rt));
         samples++;
      endfunction

      function void check_count(coeff_type actual);
         coeff_type want;
         results++;
         if (expected_counts.size() == 0) begin
            $error("comp_pressure_count: no transaction pending, got %0d", actual);
            errors++;
         end else begin
            want = expected_counts.pop_front();
            if (want !== actual) begin
               $error("comp_pressure_count: expected %0d, got %0d", want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   bpc_req_if req_ch();
   bpc_rsp_if rsp_ch();

   compensation_checker book = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit stall_request = 0;
   int coeff_sets    = 0;

   barometer_pressure_compensation dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 200000);
      $display("FAILURE");
      $finish;
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_left = 300;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 0;
            stall_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) book.check_count(rsp_ch.comp_pressure_count);
   end

   function automatic logic [RawW-1:0] pick_raw();
      case ($urandom_range(15))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h003F;
         3: return 16'hFFC0;
         default: return RawW'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] pick_coeff();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return CsrDataW'($urandom_range(65535));
      endcase
   endfunction

   task automatic write_reg(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] value);
      csr_we    = 1;
      csr_index = index;
      csr_wdata = value;
      book.write_coeff(index, value);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic load_coeffs(coeff_set_type k);
      write_reg(CSR_A0, k.a0);
      write_reg(CSR_B1, k.b1);
      write_reg(CSR_B2, k.b2);
      write_reg(CSR_C12, k.c12);
      write_reg(CSR_C11, k.c11);
      write_reg(CSR_C22, k.c22);
      coeff_sets++;
   endtask

   task automatic send_sample(logic [RawW-1:0] rp, logic [RawW-1:0] rt);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid           = 0;
         req_ch.raw_pressure    = RawW'($urandom_range(65535));
         req_ch.raw_temperature = RawW'($urandom_range(65535));
         @(negedge clock);
      end
      req_ch.valid           = 1;
      req_ch.raw_pressure    = rp;
      req_ch.raw_temperature = rt;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ch.ready;
      end
      book.note_sample(rp, rt);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid = 0;
      while (book.expected_counts.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      logic [RawW-1:0] edge_words[8];
      coeff_set_type   k;
      edge_words = '{16'h0000, 16'hFFFF, 16'h003F, 16'hFFC0,
                     16'h8000, 16'h7FFF, 16'h0040, 16'hAAAA};
      reset                  = 1;
      csr_we                 = 0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_ch.valid           = 0;
      req_ch.raw_pressure    = '0;
      req_ch.raw_temperature = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // coefficients still at reset value
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h6540, 16'h8100);
      settle();

      // typical factory-style trim values
      k.a0 = 16'h3ECE; k.b1 = 16'hB3F8; k.b2 = 16'hC517;
      k.c12 = 16'h33C8; k.c11 = 16'h0000; k.c22 = 16'h0000;
      load_coeffs(k);
      for (int i = 0; i < 8; i++) send_sample(edge_words[i], edge_words[7 - i]);
      send_sample(16'h6540, 16'h8100);
      settle();

      // extreme cross terms so every intermediate can wrap
      k.c11 = 16'h7FFF; k.c22 = 16'h8000;
      load_coeffs(k);
      for (int i = 0; i < 8; i++) send_sample(edge_words[i], edge_words[i]);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: k = {NumCoeffs{16'h7FFF}};
            1: k = {NumCoeffs{16'h8000}};
            2: k = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
            default: k = {pick_coeff(), pick_coeff(), pick_coeff(),
                          pick_coeff(), pick_coeff(), pick_coeff()};
         endcase
         load_coeffs(k);
         if (p == 4) begin
            // writes past the last register must be ignored
            write_reg(CsrIdxW'(NumCoeffs), CsrDataW'($urandom_range(65535)));
            write_reg(CsrIdxW'(NumCoeffs + 1), CsrDataW'($urandom_range(65535)));
         end
         if (p < 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 75;
         end else if (p < 6) begin
            send_idle_pct = 75;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 6) stall_request = 1;
         repeat (130) send_sample(pick_raw(), pick_raw());
         settle();
      end

      $display("Checked %0d compensated counts from %0d sample pairs across %0d coefficient sets,",
               book.results, book.samples, coeff_sets);
      $display("with both idle mixes, gap-free streaming and one long output stall.");
      if (book.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
